FILE: src/bcdrtc_pkg.sv
// Shared types, constants and BCD helper functions for the RTC reading checker.
package bcdrtc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned BitIdxW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned ValW     = 7;

  localparam logic [CfgIdxW-1:0] CfgPowerIdx  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMode24Idx = 2'd1;

  localparam logic [BitIdxW-1:0] PowerIdxRst  = 3'd7;
  localparam logic [BitIdxW-1:0] Mode24IdxRst = 3'd6;

  localparam logic [ValW-1:0] MonthMax  = 7'd12;
  localparam logic [ValW-1:0] HourMax   = 7'd24;
  localparam logic [ValW-1:0] MinSecMax = 7'd60;
  localparam logic [3:0]      MonthFeb  = 4'd2;
  localparam logic [3:0]      DigitMax  = 4'd9;

  typedef struct packed {
    logic [ByteW-1:0] status_byte;
    logic [ByteW-1:0] year_bcd;
    logic [ByteW-1:0] month_bcd;
    logic [ByteW-1:0] day_bcd;
    logic [ByteW-1:0] hour_bcd;
    logic [ByteW-1:0] minute_bcd;
    logic [ByteW-1:0] second_bcd;
  } reading_t;

  typedef struct packed {
    logic [BitIdxW-1:0] power_idx;
    logic [BitIdxW-1:0] mode24_idx;
  } cfg_t;

  typedef struct packed {
    logic power_failed;
    logic twelve_hour_mode;
    logic year_bad;
    logic month_bad;
    logic day_bad;
    logic hour_bad;
    logic minute_bad;
    logic second_bad;
  } flags_t;

  function automatic logic bcd_ok(input logic [ByteW-1:0] b);
    return (b[7:4] <= DigitMax) && (b[3:0] <= DigitMax);
  endfunction

  function automatic logic [ValW-1:0] bcd_val(input logic [ByteW-1:0] b);
    logic [ValW-1:0] tens;
    logic [ValW-1:0] units;
    tens  = {3'b000, b[7:4]};
    units = {3'b000, b[3:0]};
    return (tens * 7'd10) + units;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: src/bcd_rtc_datetime_checker.sv
// Top level of the RTC reading checker: input register, checks, result register, config.
//
// One reading is taken at every clock edge where start is high; busy is always low, so a
// new reading may follow in every cycle. Each reading produces one result, which passes through
// the input register, then the result register, and is shown for a single cycle
// with out_valid high; the receiver cannot stall. The configuration channel is always
// ready and selects which status bits report power loss and 24-hour mode; write it only
// while no reading is in flight.
module bcd_rtc_datetime_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [bcdrtc_pkg::ByteW-1:0]        in_status_byte,
  input  logic [bcdrtc_pkg::ByteW-1:0]        in_year_bcd,
  input  logic [bcdrtc_pkg::ByteW-1:0]        in_month_bcd,
  input  logic [bcdrtc_pkg::ByteW-1:0]        in_day_bcd,
  input  logic [bcdrtc_pkg::ByteW-1:0]        in_hour_bcd,
  input  logic [bcdrtc_pkg::ByteW-1:0]        in_minute_bcd,
  input  logic [bcdrtc_pkg::ByteW-1:0]        in_second_bcd,
  output logic                                out_valid,
  output logic                                out_power_failed,
  output logic                                out_twelve_hour_mode,
  output logic                                out_year_bad,
  output logic                                out_month_bad,
  output logic                                out_day_bad,
  output logic                                out_hour_bad,
  output logic                                out_minute_bad,
  output logic                                out_second_bad,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bcdrtc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [bcdrtc_pkg::CfgDataW-1:0]     cfg_data
);

  logic                  in_fire;
  logic                  cfg_fire;
  logic                  vld1_r;
  logic                  vld2_r;
  bcdrtc_pkg::reading_t  rd_r;
  bcdrtc_pkg::cfg_t      cfg_r;
  bcdrtc_pkg::cfg_t      cfg_nxt;
  bcdrtc_pkg::flags_t    flags;
  bcdrtc_pkg::flags_t    flags_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_fire   = start && !busy;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_fire) begin
      unique case (cfg_index)
        bcdrtc_pkg::CfgPowerIdx:  cfg_nxt.power_idx  = cfg_data[bcdrtc_pkg::BitIdxW-1:0];
        bcdrtc_pkg::CfgMode24Idx: cfg_nxt.mode24_idx = cfg_data[bcdrtc_pkg::BitIdxW-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r           <= 1'b0;
      vld2_r           <= 1'b0;
      cfg_r.power_idx  <= bcdrtc_pkg::PowerIdxRst;
      cfg_r.mode24_idx <= bcdrtc_pkg::Mode24IdxRst;
    end else begin
      vld1_r <= in_fire;
      vld2_r <= vld1_r;
      cfg_r  <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_r.status_byte <= in_status_byte;
      rd_r.year_bcd    <= in_year_bcd;
      rd_r.month_bcd   <= in_month_bcd;
      rd_r.day_bcd     <= in_day_bcd;
      rd_r.hour_bcd    <= in_hour_bcd;
      rd_r.minute_bcd  <= in_minute_bcd;
      rd_r.second_bcd  <= in_second_bcd;
    end
    if (vld1_r) begin
      flags_r <= flags;
    end
  end

  bcdrtc_check u_check (
    .rd    (rd_r),
    .cfg   (cfg_r),
    .flags (flags)
  );

  assign out_valid            = vld2_r;
  assign out_power_failed     = flags_r.power_failed;
  assign out_twelve_hour_mode = flags_r.twelve_hour_mode;
  assign out_year_bad         = flags_r.year_bad;
  assign out_month_bad        = flags_r.month_bad;
  assign out_day_bad          = flags_r.day_bad;
  assign out_hour_bad         = flags_r.hour_bad;
  assign out_minute_bad       = flags_r.minute_bad;
  assign out_second_bad       = flags_r.second_bad;

`ifndef SYNTHESIS
  a_beat_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> ##1 out_valid)
    else $error("accepted beat did not produce a result");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld1_r))
    else $error("result strobe without a staged beat");

  a_feb_30_bad: assert property (@(posedge clk) disable iff (!rst_n)
    vld1_r && (rd_r.month_bcd == 8'h02) && (rd_r.day_bcd == 8'h30) |=> out_day_bad)
    else $error("February 30 not flagged");

  a_cfg_power_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire && (cfg_index == bcdrtc_pkg::CfgPowerIdx) |=>
      cfg_r.power_idx == $past(cfg_data[bcdrtc_pkg::BitIdxW-1:0]))
    else $error("power bit index write lost");
`endif

endmodule

FILE: src/bcdrtc_check.sv
// Combinational validity checks on one registered RTC reading.
module bcdrtc_check (
  input  bcdrtc_pkg::reading_t rd,
  input  bcdrtc_pkg::cfg_t     cfg,
  output bcdrtc_pkg::flags_t   flags
);

  logic                         year_ok;
  logic                         month_ok;
  logic                         day_ok;
  logic [bcdrtc_pkg::ValW-1:0]  year_v;
  logic [bcdrtc_pkg::ValW-1:0]  month_v;
  logic [bcdrtc_pkg::ValW-1:0]  day_v;
  logic [4:0]                   len;
  logic                         leap;

  always_comb begin
    year_ok  = bcdrtc_pkg::bcd_ok(rd.year_bcd);
    day_ok   = bcdrtc_pkg::bcd_ok(rd.day_bcd);
    year_v   = bcdrtc_pkg::bcd_val(rd.year_bcd);
    month_v  = bcdrtc_pkg::bcd_val(rd.month_bcd);
    day_v    = bcdrtc_pkg::bcd_val(rd.day_bcd);
    month_ok = bcdrtc_pkg::bcd_ok(rd.month_bcd) && (month_v != '0) &&
               (month_v <= bcdrtc_pkg::MonthMax);
    leap     = year_ok && (year_v[1:0] == 2'b00);
    len      = bcdrtc_pkg::month_len(month_v[3:0]);
    if ((month_v[3:0] == bcdrtc_pkg::MonthFeb) && leap) begin
      len = len + 5'd1;
    end

    flags.power_failed     = rd.status_byte[cfg.power_idx];
    flags.twelve_hour_mode = ~rd.status_byte[cfg.mode24_idx];
    flags.year_bad         = ~year_ok;
    flags.month_bad        = ~month_ok;
    flags.day_bad          = ~day_ok || (month_ok && (day_v > {2'b00, len}));
    flags.hour_bad         = ~bcdrtc_pkg::bcd_ok(rd.hour_bcd) ||
                             (bcdrtc_pkg::bcd_val(rd.hour_bcd) > bcdrtc_pkg::HourMax);
    flags.minute_bad       = ~bcdrtc_pkg::bcd_ok(rd.minute_bcd) ||
                             (bcdrtc_pkg::bcd_val(rd.minute_bcd) > bcdrtc_pkg::MinSecMax);
    flags.second_bad       = ~bcdrtc_pkg::bcd_ok(rd.second_bcd) ||
                             (bcdrtc_pkg::bcd_val(rd.second_bcd) > bcdrtc_pkg::MinSecMax);
  end

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the RTC date/time reading checker.
`timescale 1ns / 100ps

module tb;

  localparam logic [bcdrtc_pkg::CfgIdxW-1:0] CfgSpareIdx = 2'd3;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [bcdrtc_pkg::ByteW-1:0]      in_status_byte = '0;
  logic [bcdrtc_pkg::ByteW-1:0]      in_year_bcd = '0;
  logic [bcdrtc_pkg::ByteW-1:0]      in_month_bcd = '0;
  logic [bcdrtc_pkg::ByteW-1:0]      in_day_bcd = '0;
  logic [bcdrtc_pkg::ByteW-1:0]      in_hour_bcd = '0;
  logic [bcdrtc_pkg::ByteW-1:0]      in_minute_bcd = '0;
  logic [bcdrtc_pkg::ByteW-1:0]      in_second_bcd = '0;
  logic                              out_valid;
  logic                              out_power_failed;
  logic                              out_twelve_hour_mode;
  logic                              out_year_bad;
  logic                              out_month_bad;
  logic                              out_day_bad;
  logic                              out_hour_bad;
  logic                              out_minute_bad;
  logic                              out_second_bad;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [bcdrtc_pkg::CfgIdxW-1:0]    cfg_index = '0;
  logic [bcdrtc_pkg::CfgDataW-1:0]   cfg_data = '0;

  logic [bcdrtc_pkg::BitIdxW-1:0]    power_sel;
  logic [bcdrtc_pkg::BitIdxW-1:0]    mode24_sel;
  bcdrtc_pkg::flags_t                expected_flags[$];
  int                                mismatches = 0;

  bcd_rtc_datetime_checker u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_status_byte       (in_status_byte),
    .in_year_bcd          (in_year_bcd),
    .in_month_bcd         (in_month_bcd),
    .in_day_bcd           (in_day_bcd),
    .in_hour_bcd          (in_hour_bcd),
    .in_minute_bcd        (in_minute_bcd),
    .in_second_bcd        (in_second_bcd),
    .out_valid            (out_valid),
    .out_power_failed     (out_power_failed),
    .out_twelve_hour_mode (out_twelve_hour_mode),
    .out_year_bad         (out_year_bad),
    .out_month_bad        (out_month_bad),
    .out_day_bad          (out_day_bad),
    .out_hour_bad         (out_hour_bad),
    .out_minute_bad       (out_minute_bad),
    .out_second_bad       (out_second_bad),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit is_bcd(input logic [bcdrtc_pkg::ByteW-1:0] b);
    return (b <= 8'h9F) && (b[3:0] <= 4'd9);
  endfunction

  function automatic int bcd_to_int(input logic [bcdrtc_pkg::ByteW-1:0] b);
    return 10 * int'(b[7:4]) + int'(b[3:0]);
  endfunction

  function automatic logic [bcdrtc_pkg::ByteW-1:0] to_bcd(input int v);
    logic [3:0] tens;
    logic [3:0] units;
    tens  = 4'(v / 10);
    units = 4'(v % 10);
    return {tens, units};
  endfunction

  function automatic int month_days(input int m, input bit leap);
    case (m)
      2:          return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic bcdrtc_pkg::flags_t judge_reading(input bcdrtc_pkg::reading_t r);
    bcdrtc_pkg::flags_t f;
    int     yr;
    int     mo;
    int     len;
    bit     leap;
    bit     month_ok;
    mo       = bcd_to_int(r.month_bcd);
    month_ok = is_bcd(r.month_bcd) && mo >= 1 && mo <= 12;
    f.power_failed     = r.status_byte[power_sel];
    f.twelve_hour_mode = ~r.status_byte[mode24_sel];
    f.year_bad         = ~is_bcd(r.year_bcd);
    f.month_bad        = ~month_ok;
    f.day_bad          = ~is_bcd(r.day_bcd);
    if (month_ok && is_bcd(r.day_bcd)) begin
      yr   = bcd_to_int(r.year_bcd) + 2000;
      leap = is_bcd(r.year_bcd) &&
             (((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0));
      len  = month_days(mo, leap);
      if (bcd_to_int(r.day_bcd) > len) f.day_bad = 1'b1;
    end
    f.hour_bad   = ~is_bcd(r.hour_bcd) || bcd_to_int(r.hour_bcd) > 24;
    f.minute_bad = ~is_bcd(r.minute_bcd) || bcd_to_int(r.minute_bcd) > 60;
    f.second_bad = ~is_bcd(r.second_bcd) || bcd_to_int(r.second_bcd) > 60;
    return f;
  endfunction

  function automatic logic [bcdrtc_pkg::ByteW-1:0] pick_bcd(input int hi);
    int r;
    r = $urandom_range(9);
    if (r < 7) return to_bcd($urandom_range(hi));
    if (r == 7) return 8'($urandom_range(255));
    return to_bcd(hi - $urandom_range(1));
  endfunction

  function automatic bcdrtc_pkg::reading_t random_reading();
    bcdrtc_pkg::reading_t r;
    r.status_byte = 8'($urandom_range(255));
    r.year_bcd    = pick_bcd(99);
    r.month_bcd   = pick_bcd(13);
    r.day_bcd     = pick_bcd(32);
    r.hour_bcd    = pick_bcd(25);
    r.minute_bcd  = pick_bcd(61);
    r.second_bcd  = pick_bcd(61);
    return r;
  endfunction

  task automatic send_reading(input bcdrtc_pkg::reading_t r);
    in_status_byte <= r.status_byte;
    in_year_bcd    <= r.year_bcd;
    in_month_bcd   <= r.month_bcd;
    in_day_bcd     <= r.day_bcd;
    in_hour_bcd    <= r.hour_bcd;
    in_minute_bcd  <= r.minute_bcd;
    in_second_bcd  <= r.second_bcd;
    start          <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    expected_flags.push_back(judge_reading(r));
  endtask

  task automatic hold_sender(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [bcdrtc_pkg::CfgIdxW-1:0]  idx,
                                input logic [bcdrtc_pkg::CfgDataW-1:0] d);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == bcdrtc_pkg::CfgPowerIdx) power_sel = d[bcdrtc_pkg::BitIdxW-1:0];
    else if (idx == bcdrtc_pkg::CfgMode24Idx) mode24_sel = d[bcdrtc_pkg::BitIdxW-1:0];
  endtask

  task automatic test_field_extremes();
    send_reading('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_reading('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_reading('{8'h40, 8'h24, 8'h12, 8'h31, 8'h24, 8'h60, 8'h60});
    send_reading('{8'h80, 8'h99, 8'h13, 8'h32, 8'h25, 8'h61, 8'h61});
    send_reading('{8'hC0, 8'h9F, 8'h01, 8'h00, 8'h00, 8'h59, 8'h59});
    send_reading('{8'h3F, 8'hA0, 8'h1A, 8'h0A, 8'hA0, 8'h9A, 8'h99});
    // day length is unknown for a bad month
    send_reading('{8'h55, 8'h09, 8'hA1, 8'h39, 8'h23, 8'h00, 8'h01});
    send_reading('{8'hAA, 8'h50, 8'h10, 8'h3A, 8'h19, 8'hF0, 8'h0F});
  endtask

  task automatic test_month_lengths();
    int len;
    for (int m = 1; m <= 12; m++) begin
      len = month_days(m, 1'b0);
      send_reading('{8'h40, 8'h23, to_bcd(m), to_bcd(len + m % 2), 8'h12, 8'h30, 8'h30});
    end
    send_reading('{8'h40, 8'h24, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00});
    send_reading('{8'h40, 8'h00, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00});
    send_reading('{8'h40, 8'h25, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00});
    // bad year in February: no leap day
    send_reading('{8'h40, 8'h2A, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00});
    send_reading('{8'h40, 8'h2A, 8'h02, 8'h28, 8'h00, 8'h00, 8'h00});
  endtask

  task automatic test_status_bit_select();
    logic [bcdrtc_pkg::CfgDataW-1:0] settings[6][2];
    settings = '{'{8'd0, 8'd0}, '{8'd7, 8'd7}, '{8'hF8, 8'hFF},
                 '{8'd3, 8'd5}, '{8'hA9, 8'h52}, '{8'd7, 8'd6}};
    foreach (settings[s]) begin
      write_register(bcdrtc_pkg::CfgPowerIdx, settings[s][0]);
      write_register(bcdrtc_pkg::CfgMode24Idx, settings[s][1]);
      if (s == 2) write_register(CfgSpareIdx, 8'hFF);
      send_reading('{8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01});
      send_reading('{8'hFF, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01});
      for (int b = 0; b < 8; b++)
        send_reading('{8'(1 << b), 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01});
    end
  endtask

  task automatic test_random_readings();
    int pcts[3];
    pcts = '{11, 46, 0};
    foreach (pcts[p]) begin
      write_register(bcdrtc_pkg::CfgPowerIdx, 8'($urandom_range(255)));
      write_register(bcdrtc_pkg::CfgMode24Idx, 8'($urandom_range(255)));
      for (int i = 0; i < 334; i++) begin
        send_reading(random_reading());
        hold_sender(pcts[p]);
      end
    end
  endtask

  task automatic check_flag(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    bcdrtc_pkg::flags_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_flags.size() == 0) begin
        $error("out_valid: expected no beat, got one");
        mismatches++;
      end else begin
        want = expected_flags.pop_front();
        check_flag("power_failed", want.power_failed, out_power_failed);
        check_flag("twelve_hour_mode", want.twelve_hour_mode, out_twelve_hour_mode);
        check_flag("year_bad", want.year_bad, out_year_bad);
        check_flag("month_bad", want.month_bad, out_month_bad);
        check_flag("day_bad", want.day_bad, out_day_bad);
        check_flag("hour_bad", want.hour_bad, out_hour_bad);
        check_flag("minute_bad", want.minute_bad, out_minute_bad);
        check_flag("second_bad", want.second_bad, out_second_bad);
      end
    end
  end

  initial begin
    power_sel  = bcdrtc_pkg::PowerIdxRst;
    mode24_sel = bcdrtc_pkg::Mode24IdxRst;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_month_lengths();
    test_status_bit_select();
    test_random_readings();
    drain_results();
    if (mismatches == 0) begin
      $display("PASS bcd_rtc_datetime_checker");
    end else begin
      $display("FAIL bcd_rtc_datetime_checker");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL bcd_rtc_datetime_checker");
    $finish;
  end

endmodule

FILE: filelist.f
src/bcdrtc_pkg.sv
src/bcdrtc_check.sv
src/bcd_rtc_datetime_checker.sv
dv/tb.sv
